// File: hdl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and constants of the contiguous fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package cfa_pkg;

  localparam int SEGMENTS = 32;
  localparam int IDX_W    = $clog2(SEGMENTS);
  localparam int CNT_W    = $clog2(SEGMENTS + 1);
  localparam int ADDR_W   = 20;
  localparam int SIZE_W   = 21;
  localparam int ID_W     = 16;
  localparam logic [SIZE_W-1:0] MEM_MAX = SIZE_W'(1) << ADDR_W;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_COMPACT = 2'd2,
    CMD_LIST    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_BAD   = 2'd3
  } policy_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP_ID   = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_NOT_FND  = 3'd3,
    ST_BAD_POL  = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_EVAL,
    OP_GRANT,
    OP_FREE,
    OP_MERGE_NEXT,
    OP_MERGE_PREV,
    OP_PACK,
    OP_PACK_END,
    OP_RESULT,
    OP_LIST
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_GRANT,
    S_FREE,
    S_NEXT,
    S_PREV,
    S_PACK,
    S_PACK_END,
    S_RESULT,
    S_LIST,
    S_WAIT
  } state_e;

  typedef struct packed {
    cmd_e cmd;
    logic scan_last;
    logic st_ok;
    logic res_last;
  } dp_stat_t;

  typedef struct packed {
    logic [SIZE_W-1:0] free_units;
    logic              segment_in_use;
    logic [ID_W-1:0]   segment_owner;
    logic [ADDR_W-1:0] segment_end;
    logic [ADDR_W-1:0] segment_start;
    logic [ADDR_W-1:0] granted_base;
    logic [2:0]        status;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/cfa_datapath.sv
// ----------------------------------------------------------------------------
// cfa_datapath
// Segment table, scan bookkeeping and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module cfa_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [cfa_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  wire cfa_pkg::dp_op_e           op_i,
  input  wire logic [1:0]                in_cmd_i,
  input  wire logic [cfa_pkg::ID_W-1:0]  in_id_i,
  input  wire logic [cfa_pkg::SIZE_W-1:0] in_size_i,
  input  wire logic [1:0]                in_pol_i,
  output cfa_pkg::dp_stat_t              stat_o,
  output cfa_pkg::result_t               res_o
);
  import cfa_pkg::*;

  logic [ADDR_W-1:0] start_q [SEGMENTS];
  logic [SIZE_W-1:0] size_q  [SEGMENTS];
  logic [ID_W-1:0]   owner_q [SEGMENTS];
  logic [SEGMENTS-1:0] used_q;
  logic [CNT_W-1:0]  count_q;
  logic [SIZE_W-1:0] free_q;

  cmd_e              cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [SIZE_W-1:0] rsize_q;
  logic [1:0]        pol_q;
  logic [IDX_W-1:0]  idx_q, hit_q, pick_q;
  logic              dup_q, pick_v_q;
  logic [SIZE_W-1:0] pick_size_q, cur_q;
  logic [ADDR_W-1:0] pick_start_q, addr_q;
  logic [CNT_W-1:0]  w_q;
  status_e           st_q;
  result_t           res_q;

  logic [ADDR_W-1:0] rd_start;
  logic [SIZE_W-1:0] rd_size;
  logic [ID_W-1:0]   rd_owner;
  logic              rd_used, last_idx, cand, better, split;
  logic [SIZE_W-1:0] clamp;
  status_e           st_c;
  logic [CNT_W-1:0]  h_plus;

  assign rd_start = start_q[idx_q];
  assign rd_size  = size_q[idx_q];
  assign rd_owner = owner_q[idx_q];
  assign rd_used  = used_q[idx_q];
  assign last_idx = ({1'b0, idx_q} == (count_q - CNT_W'(1)));
  assign split    = (pick_size_q != rsize_q);
  assign h_plus   = {1'b0, hit_q} + CNT_W'(1);

  always_comb begin
    cand   = !rd_used && (rd_size >= rsize_q);
    better = !pick_v_q ||
             ((pol_q == POL_BEST) && (rd_size < pick_size_q)) ||
             ((pol_q == POL_WORST) && (rd_size > pick_size_q));
    if (pol_q == POL_FIRST) better = !pick_v_q;
    clamp = cfg_wdata_i;
    if (cfg_wdata_i < SIZE_W'(2)) clamp = SIZE_W'(2);
    if (cfg_wdata_i > MEM_MAX) clamp = MEM_MAX;
    st_c = ST_OK;
    unique case (cmd_q)
      CMD_REQUEST: begin
        if (dup_q) st_c = ST_DUP_ID;
        else if (pol_q == POL_BAD) st_c = ST_BAD_POL;
        else if ((rsize_q == '0) || !pick_v_q) st_c = ST_NO_SPACE;
        else if (split && (count_q == CNT_W'(SEGMENTS))) st_c = ST_FULL;
      end
      CMD_RELEASE: if (!dup_q) st_c = ST_NOT_FND;
      default: st_c = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      count_q    <= CNT_W'(1);
      free_q     <= MEM_MAX;
      start_q[0] <= '0;
      size_q[0]  <= MEM_MAX;
    end else if (cfg_we_i) begin
      free_q     <= clamp;
      used_q     <= '0;
      count_q    <= CNT_W'(1);
      start_q[0] <= '0;
      size_q[0]  <= clamp;
    end else begin
      unique case (op_i)
        OP_LOAD: begin
          cmd_q    <= cmd_e'(in_cmd_i);
          id_q     <= in_id_i;
          rsize_q  <= in_size_i;
          pol_q    <= in_pol_i;
          idx_q    <= '0;
          dup_q    <= 1'b0;
          pick_v_q <= 1'b0;
          w_q      <= '0;
          addr_q   <= '0;
        end
        OP_SCAN: begin
          if (rd_used && (rd_owner == id_q) && !dup_q) begin
            dup_q <= 1'b1;
            hit_q <= idx_q;
          end
          if (cand && better) begin
            pick_v_q     <= 1'b1;
            pick_q       <= idx_q;
            pick_size_q  <= rd_size;
            pick_start_q <= rd_start;
          end
          idx_q <= idx_q + IDX_W'(1);
        end
        OP_EVAL: begin
          st_q  <= st_c;
          idx_q <= hit_q;
        end
        OP_GRANT: begin
          for (int j = SEGMENTS - 1; j >= 0; j--) begin
            if (split && (j > int'(pick_q) + 1)) begin
              start_q[j] <= start_q[j-1];
              size_q[j]  <= size_q[j-1];
              owner_q[j] <= owner_q[j-1];
              used_q[j]  <= used_q[j-1];
            end else if (split && (j == int'(pick_q) + 1)) begin
              start_q[j] <= pick_start_q + rsize_q[ADDR_W-1:0];
              size_q[j]  <= pick_size_q - rsize_q;
              owner_q[j] <= '0;
              used_q[j]  <= 1'b0;
            end else if (j == int'(pick_q)) begin
              size_q[j]  <= rsize_q;
              owner_q[j] <= id_q;
              used_q[j]  <= 1'b1;
            end
          end
          if (split) count_q <= count_q + CNT_W'(1);
          free_q <= free_q - rsize_q;
        end
        OP_FREE: begin
          used_q[hit_q]  <= 1'b0;
          owner_q[hit_q] <= '0;
          free_q         <= free_q + rd_size;
          cur_q          <= rd_size;
          idx_q          <= idx_q + IDX_W'(1);
        end
        OP_MERGE_NEXT: begin
          // coalesce with the free neighbor above, if there is one
          if ((h_plus < count_q) && !rd_used) begin
            size_q[hit_q] <= cur_q + rd_size;
            cur_q         <= cur_q + rd_size;
            for (int j = 0; j < SEGMENTS - 1; j++) begin
              if (j > int'(hit_q)) begin
                start_q[j] <= start_q[j+1];
                size_q[j]  <= size_q[j+1];
                owner_q[j] <= owner_q[j+1];
                used_q[j]  <= used_q[j+1];
              end
            end
            count_q <= count_q - CNT_W'(1);
          end
          idx_q <= hit_q - IDX_W'(1);
        end
        OP_MERGE_PREV: begin
          if ((hit_q != '0) && !rd_used) begin
            size_q[idx_q] <= rd_size + cur_q;
            for (int j = 0; j < SEGMENTS - 1; j++) begin
              if (j >= int'(hit_q)) begin
                start_q[j] <= start_q[j+1];
                size_q[j]  <= size_q[j+1];
                owner_q[j] <= owner_q[j+1];
                used_q[j]  <= used_q[j+1];
              end
            end
            count_q <= count_q - CNT_W'(1);
          end
        end
        OP_PACK: begin
          if (rd_used) begin
            start_q[w_q[IDX_W-1:0]] <= addr_q;
            size_q[w_q[IDX_W-1:0]]  <= rd_size;
            owner_q[w_q[IDX_W-1:0]] <= rd_owner;
            used_q[w_q[IDX_W-1:0]]  <= 1'b1;
            addr_q <= addr_q + rd_size[ADDR_W-1:0];
            w_q    <= w_q + CNT_W'(1);
          end
          idx_q <= idx_q + IDX_W'(1);
        end
        OP_PACK_END: begin
          if (free_q != '0) begin
            start_q[w_q[IDX_W-1:0]] <= addr_q;
            size_q[w_q[IDX_W-1:0]]  <= free_q;
            owner_q[w_q[IDX_W-1:0]] <= '0;
            used_q[w_q[IDX_W-1:0]]  <= 1'b0;
            count_q <= w_q + CNT_W'(1);
          end else begin
            count_q <= w_q;
          end
          st_q <= ST_OK;
        end
        OP_RESULT: begin
          res_q.status         <= st_q;
          res_q.granted_base   <= ((cmd_q == CMD_REQUEST) && (st_q == ST_OK)) ?
                                  pick_start_q : '0;
          res_q.segment_start  <= '0;
          res_q.segment_end    <= '0;
          res_q.segment_owner  <= '0;
          res_q.segment_in_use <= 1'b0;
          res_q.free_units     <= free_q;
        end
        OP_LIST: begin
          res_q.status         <= ST_OK;
          res_q.granted_base   <= '0;
          res_q.segment_start  <= rd_start;
          res_q.segment_end    <= rd_start + rd_size[ADDR_W-1:0] - ADDR_W'(1);
          res_q.segment_owner  <= rd_used ? rd_owner : '0;
          res_q.segment_in_use <= rd_used;
          res_q.free_units     <= free_q;
          idx_q <= idx_q + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  // listing stops after the entry that was just put in the result register
  logic list_last_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_last_q <= 1'b1;
    end else if (op_i == OP_LIST) begin
      list_last_q <= last_idx;
    end else if (op_i == OP_RESULT) begin
      list_last_q <= 1'b1;
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.scan_last = last_idx;
  assign stat_o.st_ok     = (st_q == ST_OK);
  assign stat_o.res_last  = list_last_q;
  assign res_o            = res_q;

endmodule
`default_nettype wire

// File: hdl/cfa_ctrl.sv
// ----------------------------------------------------------------------------
// cfa_ctrl
// Command sequencer: steps the datapath through scans, updates and results.
// ----------------------------------------------------------------------------
`default_nettype none
module cfa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        in_cmd_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire cfa_pkg::dp_stat_t stat_i,
  output cfa_pkg::dp_op_e        op_o
);
  import cfa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_o        = OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o = OP_LOAD;
          case (in_cmd_i)
            CMD_COMPACT: state_d = S_PACK;
            CMD_LIST:    state_d = S_LIST;
            default:     state_d = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        op_o = OP_SCAN;
        if (stat_i.scan_last) state_d = S_EVAL;
      end
      S_EVAL: begin
        op_o = OP_EVAL;
        state_d = (stat_i.cmd == CMD_REQUEST) ? S_GRANT : S_FREE;
      end
      S_GRANT: begin
        if (stat_i.st_ok) op_o = OP_GRANT;
        state_d = S_RESULT;
      end
      S_FREE: begin
        if (stat_i.st_ok) begin
          op_o = OP_FREE;
          state_d = S_NEXT;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_NEXT: begin
        op_o = OP_MERGE_NEXT;
        state_d = S_PREV;
      end
      S_PREV: begin
        op_o = OP_MERGE_PREV;
        state_d = S_RESULT;
      end
      S_PACK: begin
        op_o = OP_PACK;
        if (stat_i.scan_last) state_d = S_PACK_END;
      end
      S_PACK_END: begin
        op_o = OP_PACK_END;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        op_o = OP_RESULT;
        state_d = S_WAIT;
      end
      S_LIST: begin
        op_o = OP_LIST;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = stat_i.res_last ? S_IDLE : S_LIST;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/contiguous_fit_allocator_core.sv
// one command at a time, one table entry scanned per cycle through a single read port;
// next command taken the cycle after its last word leaves
// reset (async, active low) leaves one free segment of 2^20 units; a size
// write reinitializes the table the same way, clamping the written value to 2..2^20 as the new size
// ----------------------------------------------------------------------------
// contiguous_fit_allocator_core
// Contiguous segment allocator with first, best and worst fit.
// ----------------------------------------------------------------------------
`default_nettype none
module contiguous_fit_allocator_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [cfa_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // owner_id[15:0], request_size[36:16], fit_policy[38:37], zero pad
  input  wire logic [39:0]                s_axis_tdata_i,
  // command
  input  wire logic [1:0]                 s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  // status[2:0], granted_base[22:3], segment_start[42:23], segment_end[62:43],
  // segment_owner[78:63], segment_in_use[79], free_units[100:80], zero pad
  output logic [103:0]                    m_axis_tdata_o,
  output logic                            m_axis_tlast_o
);
  import cfa_pkg::*;

  dp_stat_t stat;
  dp_op_e   op;
  result_t  res;

  cfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .op_o        (op)
  );

  cfa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (op),
    .in_cmd_i    (s_axis_tuser_i),
    .in_id_i     (s_axis_tdata_i[15:0]),
    .in_size_i   (s_axis_tdata_i[36:16]),
    .in_pol_i    (s_axis_tdata_i[38:37]),
    .stat_o      (stat),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {3'b000, res};
  assign m_axis_tlast_o = stat.res_last;

endmodule
`default_nettype wire

// File: hdl/cfa_checker.sv
// ----------------------------------------------------------------------------
// cfa_checker
// Port-level checks of the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module cfa_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid_i,
  input wire logic         s_axis_tready_o,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [103:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("command taken while a result word is pending");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o && !m_axis_tvalid_o)
    else $error("core not busy after taking a command");

  a_fail_no_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[2:0] != 3'd0) |-> m_axis_tdata_o[22:3] == 20'd0)
    else $error("granted base set on a refused command");

endmodule

bind contiguous_fit_allocator_core cfa_checker u_cfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire

// File: test/contiguous_fit_allocator_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contiguous_fit_allocator_core_test
// Drives request, release, compaction and listing commands into the allocator
// and checks every output word against a segment table kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none
module contiguous_fit_allocator_core_test;
  import cfa_pkg::*;

  localparam int SEGS = 32;

  typedef struct {
    logic [2:0]  status;
    logic [19:0] base;
    logic [19:0] seg_lo;
    logic [19:0] seg_hi;
    logic [15:0] owner;
    logic        in_use;
    logic [20:0] free_units;
    logic        last;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [20:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic [1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [103:0] m_axis_tdata_o;
  logic m_axis_tlast_o;

  contiguous_fit_allocator_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i), .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o), .m_axis_tlast_o(m_axis_tlast_o)
  );

  always #4 clk_i = ~clk_i;

  // bench copy of the segment table
  logic [20:0] tbl_start [SEGS];
  logic [20:0] tbl_size [SEGS];
  logic [15:0] tbl_owner [SEGS];
  logic        tbl_used [SEGS];
  int          tbl_count;
  logic [20:0] mem_free;
  logic [20:0] mem_total;

  word_t expected_words[$];
  int errors = 0;
  bit sink_hold = 0;
  bit sink_steady = 0;
  bit src_steady = 0;
  logic [15:0] live_ids[$];

  function automatic void table_init(logic [20:0] total);
    mem_total = total;
    for (int i = 0; i < SEGS; i++) begin
      tbl_start[i] = '0; tbl_size[i] = '0; tbl_owner[i] = '0; tbl_used[i] = 0;
    end
    tbl_size[0] = total;
    tbl_count = 1;
    mem_free = total;
  endfunction

  function automatic int owner_slot(logic [15:0] id);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_used[i] && tbl_owner[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int j);
    for (int k = j; k < tbl_count - 1; k++) begin
      tbl_start[k] = tbl_start[k+1]; tbl_size[k] = tbl_size[k+1];
      tbl_owner[k] = tbl_owner[k+1]; tbl_used[k] = tbl_used[k+1];
    end
    tbl_count--;
  endfunction

  function automatic logic [2:0] alloc_segment(logic [15:0] id, logic [20:0] sz,
                                               policy_e pol, output logic [19:0] base);
    int pick;
    logic [20:0] rem;
    pick = -1;
    base = '0;
    if (owner_slot(id) >= 0) return ST_DUP_ID;
    if (pol == POL_BAD) return ST_BAD_POL;
    if (sz == 0) return ST_NO_SPACE;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_used[i] || tbl_size[i] < sz) continue;
      if (pol == POL_FIRST) begin
        pick = i;
        break;
      end
      if (pick < 0 || (pol == POL_BEST && tbl_size[i] < tbl_size[pick]) ||
          (pol == POL_WORST && tbl_size[i] > tbl_size[pick]))
        pick = i;
    end
    if (pick < 0) return ST_NO_SPACE;
    rem = tbl_size[pick] - sz;
    if (rem > 0) begin
      if (tbl_count >= SEGS) return ST_FULL;
      for (int k = tbl_count; k > pick + 1; k--) begin
        tbl_start[k] = tbl_start[k-1]; tbl_size[k] = tbl_size[k-1];
        tbl_owner[k] = tbl_owner[k-1]; tbl_used[k] = tbl_used[k-1];
      end
      tbl_count++;
      tbl_start[pick+1] = tbl_start[pick] + sz;
      tbl_size[pick+1] = rem; tbl_owner[pick+1] = '0; tbl_used[pick+1] = 0;
    end
    tbl_size[pick] = sz; tbl_owner[pick] = id; tbl_used[pick] = 1;
    mem_free -= sz;
    base = tbl_start[pick][19:0];
    return ST_OK;
  endfunction

  function automatic logic [2:0] free_segment(logic [15:0] id);
    int i;
    i = owner_slot(id);
    if (i < 0) return ST_NOT_FND;
    mem_free += tbl_size[i];
    tbl_used[i] = 0; tbl_owner[i] = '0;
    if (i + 1 < tbl_count && !tbl_used[i+1]) begin
      tbl_size[i] += tbl_size[i+1];
      drop_slot(i + 1);
    end
    if (i > 0 && !tbl_used[i-1]) begin
      tbl_size[i-1] += tbl_size[i];
      drop_slot(i);
    end
    return ST_OK;
  endfunction

  function automatic void pack_segments();
    int w;
    logic [20:0] addr;
    w = 0; addr = '0;
    for (int r = 0; r < tbl_count; r++) begin
      if (!tbl_used[r]) continue;
      tbl_start[w] = addr; tbl_size[w] = tbl_size[r];
      tbl_owner[w] = tbl_owner[r]; tbl_used[w] = 1;
      addr += tbl_size[r];
      w++;
    end
    if (mem_free > 0 && w < SEGS) begin
      tbl_start[w] = addr; tbl_size[w] = mem_free; tbl_owner[w] = '0; tbl_used[w] = 0;
      w++;
    end
    tbl_count = w;
  endfunction

  function automatic void predict_words(cmd_e cmd, logic [15:0] id, logic [20:0] sz,
                                        policy_e pol);
    word_t w;
    logic [2:0] st;
    logic [19:0] base;
    st = ST_OK; base = '0;
    if (cmd == CMD_LIST) begin
      for (int i = 0; i < tbl_count; i++) begin
        w.status = ST_OK; w.base = '0;
        w.seg_lo = tbl_start[i][19:0];
        w.seg_hi = 20'(tbl_start[i] + tbl_size[i] - 1);
        w.owner = tbl_used[i] ? tbl_owner[i] : '0;
        w.in_use = tbl_used[i]; w.free_units = mem_free;
        w.last = (i == tbl_count - 1);
        expected_words.push_back(w);
      end
      return;
    end
    if (cmd == CMD_REQUEST) st = alloc_segment(id, sz, pol, base);
    else if (cmd == CMD_RELEASE) st = free_segment(id);
    else pack_segments();
    w.status = st; w.base = base; w.seg_lo = '0; w.seg_hi = '0; w.owner = '0;
    w.in_use = 0; w.free_units = mem_free; w.last = 1;
    expected_words.push_back(w);
  endfunction

  // sends one command word, idling now and then before it
  task automatic send_cmd(cmd_e cmd, logic [15:0] id, logic [20:0] sz, policy_e pol);
    while (!src_steady && $urandom_range(99) < 10) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {1'b0, pol, sz, id};
    s_axis_tuser_i <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_words(cmd, id, sz, pol);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_size(logic [20:0] val);
    logic [20:0] v;
    drain();
    v = val;
    if (v < 2) v = 2;
    if (v > MEM_MAX) v = MEM_MAX;
    cfg_we_i <= 1'b1; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    table_init(v);
    live_ids.delete();
  endtask

  // sink side handshake
  always @(posedge clk_i) begin
    m_axis_tready_i <= !sink_hold && (sink_steady || $urandom_range(99) >= 10);
  end

  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word %h", m_axis_tdata_o);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (m_axis_tdata_o[2:0] !== w.status) begin
          $error("status exp %0d got %0d", w.status, m_axis_tdata_o[2:0]); errors++;
        end
        if (m_axis_tdata_o[22:3] !== w.base) begin
          $error("granted_base exp %0h got %0h", w.base, m_axis_tdata_o[22:3]); errors++;
        end
        if (m_axis_tdata_o[42:23] !== w.seg_lo) begin
          $error("segment_start exp %0h got %0h", w.seg_lo, m_axis_tdata_o[42:23]);
          errors++;
        end
        if (m_axis_tdata_o[62:43] !== w.seg_hi) begin
          $error("segment_end exp %0h got %0h", w.seg_hi, m_axis_tdata_o[62:43]); errors++;
        end
        if (m_axis_tdata_o[78:63] !== w.owner) begin
          $error("segment_owner exp %0h got %0h", w.owner, m_axis_tdata_o[78:63]); errors++;
        end
        if (m_axis_tdata_o[79] !== w.in_use) begin
          $error("segment_in_use exp %0b got %0b", w.in_use, m_axis_tdata_o[79]); errors++;
        end
        if (m_axis_tdata_o[100:80] !== w.free_units) begin
          $error("free_units exp %0h got %0h", w.free_units, m_axis_tdata_o[100:80]);
          errors++;
        end
        if (m_axis_tlast_o !== w.last) begin
          $error("last exp %0b got %0b", w.last, m_axis_tlast_o); errors++;
        end
      end
    end
  end

  function automatic logic [15:0] fresh_id();
    return 16'($urandom_range(65535));
  endfunction

  task automatic test_directed();
    send_cmd(CMD_LIST, 16'h0, 21'd0, POL_FIRST);
    send_cmd(CMD_REQUEST, 16'h0000, 21'd0, POL_FIRST);          // zero size
    send_cmd(CMD_REQUEST, 16'h0000, 21'd100, POL_FIRST);        // id zero
    send_cmd(CMD_REQUEST, 16'h0000, 21'd5, POL_BEST);           // duplicate
    send_cmd(CMD_REQUEST, 16'hFFFF, 21'd50, POL_BAD);
    send_cmd(CMD_REQUEST, 16'hFFFF, 21'h1FFFFF, POL_WORST);     // no space
    send_cmd(CMD_REQUEST, 16'hFFFF, 21'd200, POL_WORST);
    send_cmd(CMD_REQUEST, 16'h4142, 21'd300, POL_BEST);
    send_cmd(CMD_RELEASE, 16'h0000, 21'd0, POL_FIRST);
    send_cmd(CMD_RELEASE, 16'h1234, 21'd0, POL_FIRST);          // unknown id
    send_cmd(CMD_REQUEST, 16'h5555, 21'd100, POL_BEST);         // exact fit in hole
    send_cmd(CMD_RELEASE, 16'hFFFF, 21'd0, POL_FIRST);
    send_cmd(CMD_LIST, 16'h0, 21'd0, POL_FIRST);
    send_cmd(CMD_COMPACT, 16'h0, 21'd0, POL_FIRST);
    send_cmd(CMD_LIST, 16'h0, 21'd0, POL_FIRST);
    write_size(21'd0);                                           // clamps to two
    send_cmd(CMD_REQUEST, 16'h0001, 21'd2, POL_FIRST);
    send_cmd(CMD_COMPACT, 16'h0, 21'd0, POL_FIRST);             // no free units
    send_cmd(CMD_LIST, 16'h0, 21'd0, POL_FIRST);
    write_size(21'h1FFFFF);                                      // clamps to max
    send_cmd(CMD_REQUEST, 16'h0002, MEM_MAX, POL_WORST);
    send_cmd(CMD_RELEASE, 16'h0002, 21'd0, POL_FIRST);
  endtask

  // fill the table with small pieces until a split is refused
  task automatic test_table_full();
    write_size(21'd40);
    for (int i = 0; i < 33; i++)
      send_cmd(CMD_REQUEST, 16'(16'h100 + i), 21'd1, POL_FIRST);
    send_cmd(CMD_REQUEST, 16'h0200, 21'd9, POL_FIRST);           // exact fit still ok
    send_cmd(CMD_LIST, 16'h0, 21'd0, POL_FIRST);
  endtask

  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1;
        repeat (300) @(posedge clk_i);
        sink_hold = 0;
      end
      for (int i = 0; i < 6; i++)
        send_cmd(i % 2 ? CMD_LIST : CMD_REQUEST, 16'(16'h300 + i), 21'd3, POL_BEST);
    join
    drain();
  endtask

  task automatic test_random(int n, logic [20:0] size);
    int sel;
    logic [15:0] id;
    write_size(size);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      src_steady = (i > n / 2 && i < n / 2 + 15);
      sink_steady = src_steady;
      if (sel < 50) begin
        id = ($urandom_range(9) == 0 && live_ids.size() != 0) ?
             live_ids[$urandom_range(live_ids.size() - 1)] : fresh_id();
        send_cmd(CMD_REQUEST, id,
                 $urandom_range(19) == 0 ? 21'($urandom) : 21'($urandom_range(size / 6 + 1)),
                 policy_e'($urandom_range(9) == 0 ? 3 : $urandom_range(2)));
        if (expected_words[$].status == ST_OK) live_ids.push_back(id);
      end else if (sel < 80) begin
        if (live_ids.size() != 0 && $urandom_range(9) != 0) begin
          sel = $urandom_range(live_ids.size() - 1);
          id = live_ids[sel];
          live_ids.delete(sel);
        end else id = fresh_id();
        send_cmd(CMD_RELEASE, id, 21'($urandom), policy_e'($urandom_range(3)));
      end else if (sel < 90) send_cmd(CMD_COMPACT, fresh_id(), 21'($urandom), POL_FIRST);
      else send_cmd(CMD_LIST, fresh_id(), 21'($urandom), policy_e'($urandom_range(3)));
    end
    src_steady = 0; sink_steady = 0;
    drain();                                                     // sender pause
  endtask

  initial begin
    table_init(MEM_MAX);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random(20, 21'd1000);
    test_random(20, 21'd64);
    test_random(10, MEM_MAX);
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
